@@ rtl/esc_pkg.sv @@
// Package: widths, constant divisors, reciprocals and calendar tables.
`default_nettype none
package esc_pkg;

  localparam int unsigned InW       = 31;
  localparam int unsigned OutW      = 40;
  localparam int unsigned InTdataW  = 32;

  localparam int unsigned SecW      = 6;
  localparam int unsigned MinW      = 6;
  localparam int unsigned HourW     = 5;
  localparam int unsigned DomW      = 5;
  localparam int unsigned MonW      = 4;
  localparam int unsigned YearW     = 11;
  localparam int unsigned WdayW     = 3;

  localparam int unsigned DaysW     = 15;
  localparam int unsigned HmsW      = 17;
  localparam int unsigned RestW     = 12;
  localparam int unsigned DayInYrW  = 9;

  // seconds per day = 675 * 128
  localparam logic [9:0]  DayDiv    = 10'd675;
  localparam logic [24:0] DayRecip  = 25'd25451658;
  localparam int unsigned DayShift  = 34;

  // seconds per hour = 225 * 16
  localparam logic [7:0]  HourDiv   = 8'd225;
  localparam logic [12:0] HourRecip = 13'd4660;
  localparam int unsigned HourShift = 20;

  // seconds per minute = 15 * 4
  localparam logic [3:0]  MinDiv    = 4'd15;
  localparam logic [12:0] MinRecip  = 13'd4369;
  localparam int unsigned MinShift  = 16;

  // days per four-year cycle
  localparam logic [10:0] CycDiv    = 11'd1461;
  localparam logic [14:0] CycRecip  = 15'd22966;
  localparam int unsigned CycShift  = 25;

  localparam logic [YearW-1:0] FirstYear = 11'd1970;
  localparam logic [1:0]       LeapSlot  = 2'd2;
  localparam logic [2:0]       WeekDiv   = 3'd7;
  localparam logic [2:0]       EpochWday = 3'd4;

  function automatic logic [10:0] year_off(input logic [1:0] yi);
    logic [10:0] r;
    case (yi)
      2'd0:    r = 11'd0;
      2'd1:    r = 11'd365;
      2'd2:    r = 11'd730;
      default: r = 11'd1096;
    endcase
    return r;
  endfunction

  function automatic logic [DayInYrW-1:0] month_start(input logic [3:0] m,
                                                      input logic       leap);
    logic [DayInYrW-1:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    if (leap && (m >= 4'd2) && (m <= 4'd11)) begin
      r = r + 9'd1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/epoch_seconds_to_calendar_unit.sv @@
// Top level: seconds-since-1970 to calendar date and time, nine-stage pipeline.
//
// Input channel s_axis: one item is a 31-bit count of seconds since
// 1970-01-01 00:00:00 in tdata[30:0]; tdata[31] is ignored.
// Output channel m_axis: one item per input item, in order, with second,
// minute, hour, day of month, month, year and weekday packed in tdata.
// Throughput: one item per cycle while the receiver does not stall; the nine
// register stages split the work into multiply, remainder and correction steps.
// Days are split by 86400, hours by 3600, minutes by 60, four-year cycles
// by 1461, each as multiply, remainder, then a one-step correction.
// Reset clears all stage valid bits; no item is in flight afterwards.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready_o drops; nothing is lost or repeated. Bubbles in the
// pipeline do not fill while stalled, so a stall costs its own length.
`default_nettype none
module epoch_seconds_to_calendar_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [30:0] epoch_seconds, [31] zero
  input  wire logic [esc_pkg::InTdataW-1:0] s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month,
  // [25:22] month, [36:26] year, [39:37] weekday
  output logic [esc_pkg::OutW-1:0]          m_axis_tdata_o
);

  localparam int unsigned NStg = 9;

  logic             en;
  logic [NStg-1:0]  v_q;

  assign en              = !v_q[NStg-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = v_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NStg-2:0], s_axis_tvalid_i};
    end
  end

  // stage 1: day quotient estimate
  logic [23:0]                 x1_d;
  logic [48:0]                 p1;
  logic [esc_pkg::DaysW-1:0]   q1_q;
  logic [23:0]                 x1_q;
  logic [6:0]                  lo1_q;

  assign x1_d = s_axis_tdata_i[30:7];
  assign p1   = 49'(x1_d) * 49'(esc_pkg::DayRecip);

  // stage 2: day remainder
  logic [24:0]                 p2;
  logic [10:0]                 r2_q;
  logic [esc_pkg::DaysW-1:0]   q2_q;
  logic [6:0]                  lo2_q;

  assign p2 = 25'(q1_q) * 25'(esc_pkg::DayDiv);

  // stage 3: day correction
  logic                        c3;
  logic [10:0]                 rr3;
  logic [esc_pkg::DaysW-1:0]   days3_q;
  logic [esc_pkg::HmsW-1:0]    hms3_q;

  assign c3  = (r2_q >= 11'(esc_pkg::DayDiv));
  assign rr3 = c3 ? (r2_q - 11'(esc_pkg::DayDiv)) : r2_q;

  // stage 4: hour and cycle estimates, weekday
  logic [25:0]                 p4h;
  logic [29:0]                 p4c;
  logic [15:0]                 w4;
  logic [5:0]                  ws4;
  logic [3:0]                  wf4;
  logic [3:0]                  wm4;
  logic [4:0]                  h4_q;
  logic [4:0]                  c4_q;
  logic [esc_pkg::DaysW-1:0]   days4_q;
  logic [esc_pkg::HmsW-1:0]    hms4_q;
  logic [esc_pkg::WdayW-1:0]   wd4_q;

  assign p4h = 26'(hms3_q[16:4]) * 26'(esc_pkg::HourRecip);
  assign p4c = 30'(days3_q) * 30'(esc_pkg::CycRecip);
  assign w4  = 16'(days3_q) + 16'(esc_pkg::EpochWday);
  assign ws4 = 6'(w4[2:0]) + 6'(w4[5:3]) + 6'(w4[8:6]) + 6'(w4[11:9])
             + 6'(w4[14:12]) + 6'(w4[15]);
  assign wf4 = 4'(ws4[5:3]) + 4'(ws4[2:0]);
  assign wm4 = (wf4 >= 4'(esc_pkg::WeekDiv)) ? (wf4 - 4'(esc_pkg::WeekDiv)) : wf4;

  // stage 5: hour and cycle remainders
  logic [12:0]                 ph5;
  logic [15:0]                 pc5;
  logic [8:0]                  hr5_q;
  logic [11:0]                 dr5_q;
  logic [4:0]                  h5_q;
  logic [4:0]                  c5_q;
  logic [3:0]                  lo5_q;
  logic [esc_pkg::WdayW-1:0]   wd5_q;

  assign ph5 = 13'(h4_q) * 13'(esc_pkg::HourDiv);
  assign pc5 = 16'(c4_q) * 16'(esc_pkg::CycDiv);

  // stage 6: hour and cycle correction
  logic                        ch6;
  logic                        cc6;
  logic [8:0]                  hrr6;
  logic [11:0]                 drr6;
  logic [esc_pkg::HourW-1:0]   hour6_q;
  logic [esc_pkg::RestW-1:0]   rest6_q;
  logic [4:0]                  cyc6_q;
  logic [10:0]                 dc6_q;
  logic [esc_pkg::WdayW-1:0]   wd6_q;

  assign ch6  = (hr5_q >= 9'(esc_pkg::HourDiv));
  assign hrr6 = ch6 ? (hr5_q - 9'(esc_pkg::HourDiv)) : hr5_q;
  assign cc6  = (dr5_q >= 12'(esc_pkg::CycDiv));
  assign drr6 = cc6 ? (dr5_q - 12'(esc_pkg::CycDiv)) : dr5_q;

  // stage 7: minute estimate, year within cycle
  logic [22:0]                 p7;
  logic [1:0]                  yi7;
  logic [10:0]                 dy7;
  logic [5:0]                  m7_q;
  logic [esc_pkg::RestW-1:0]   rest7_q;
  logic [esc_pkg::HourW-1:0]   hour7_q;
  logic [esc_pkg::YearW-1:0]   year7_q;
  logic                        leap7_q;
  logic [esc_pkg::DayInYrW-1:0] dy7_q;
  logic [esc_pkg::WdayW-1:0]   wd7_q;

  assign p7  = 23'(rest6_q[11:2]) * 23'(esc_pkg::MinRecip);
  assign yi7 = (dc6_q < esc_pkg::year_off(2'd1)) ? 2'd0 :
               (dc6_q < esc_pkg::year_off(2'd2)) ? 2'd1 :
               (dc6_q < esc_pkg::year_off(2'd3)) ? 2'd2 : 2'd3;
  assign dy7 = dc6_q - esc_pkg::year_off(yi7);

  // stage 8: minute remainder, month search
  logic [9:0]                  pm8;
  logic [3:0]                  mon8;
  logic [4:0]                  mr8_q;
  logic [5:0]                  m8_q;
  logic [1:0]                  lo8_q;
  logic [esc_pkg::HourW-1:0]   hour8_q;
  logic [esc_pkg::YearW-1:0]   year8_q;
  logic                        leap8_q;
  logic [esc_pkg::DayInYrW-1:0] dy8_q;
  logic [3:0]                  mon8_q;
  logic [esc_pkg::WdayW-1:0]   wd8_q;

  assign pm8 = 10'(m7_q) * 10'(esc_pkg::MinDiv);

  always_comb begin
    mon8 = '0;
    for (int m = 1; m < 12; m++) begin
      if (dy7_q >= esc_pkg::month_start(4'(m), leap7_q)) begin
        mon8 = mon8 + 4'd1;
      end
    end
  end

  // stage 9: minute correction, day of month, output register
  logic                        cm9;
  logic [4:0]                  mrr9;
  logic [esc_pkg::SecW-1:0]    sec9;
  logic [esc_pkg::MinW-1:0]    min9;
  logic [esc_pkg::DayInYrW-1:0] dom9;
  logic [esc_pkg::OutW-1:0]    out_d;
  logic [esc_pkg::OutW-1:0]    out_q;

  assign cm9  = (mr8_q >= 5'(esc_pkg::MinDiv));
  assign mrr9 = cm9 ? (mr8_q - 5'(esc_pkg::MinDiv)) : mr8_q;
  assign sec9 = {mrr9[3:0], lo8_q};
  assign min9 = cm9 ? (m8_q + 6'd1) : m8_q;
  assign dom9 = dy8_q - esc_pkg::month_start(mon8_q, leap8_q) + 9'd1;
  assign out_d = {wd8_q, year8_q, mon8_q + 4'd1, dom9[4:0], hour8_q, min9, sec9};

  assign m_axis_tdata_o = out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_q    <= p1[48:34];
      x1_q    <= x1_d;
      lo1_q   <= s_axis_tdata_i[6:0];

      r2_q    <= 11'(25'(x1_q) - p2);
      q2_q    <= q1_q;
      lo2_q   <= lo1_q;

      days3_q <= c3 ? (q2_q + 15'd1) : q2_q;
      hms3_q  <= {rr3[9:0], lo2_q};

      h4_q    <= p4h[24:20];
      c4_q    <= p4c[29:25];
      days4_q <= days3_q;
      hms4_q  <= hms3_q;
      wd4_q   <= wm4[2:0];

      hr5_q   <= 9'(hms4_q[16:4] - ph5);
      dr5_q   <= 12'(16'(days4_q) - pc5);
      h5_q    <= h4_q;
      c5_q    <= c4_q;
      lo5_q   <= hms4_q[3:0];
      wd5_q   <= wd4_q;

      hour6_q <= ch6 ? (h5_q + 5'd1) : h5_q;
      rest6_q <= {hrr6[7:0], lo5_q};
      cyc6_q  <= cc6 ? (c5_q + 5'd1) : c5_q;
      dc6_q   <= drr6[10:0];
      wd6_q   <= wd5_q;

      m7_q    <= p7[21:16];
      rest7_q <= rest6_q;
      hour7_q <= hour6_q;
      year7_q <= esc_pkg::FirstYear + {4'd0, cyc6_q, 2'd0} + 11'(yi7);
      leap7_q <= (yi7 == esc_pkg::LeapSlot);
      dy7_q   <= dy7[8:0];
      wd7_q   <= wd6_q;

      mr8_q   <= 5'(rest7_q[11:2] - pm8);
      m8_q    <= m7_q;
      lo8_q   <= rest7_q[1:0];
      hour8_q <= hour7_q;
      year8_q <= year7_q;
      leap8_q <= leap7_q;
      dy8_q   <= dy7_q;
      mon8_q  <= mon8;
      wd8_q   <= wd7_q;

      out_q   <= out_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/esc_checker.sv @@
// Checker: port-level properties of the calendar unit, bound to the top level.
`default_nettype none
module esc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid_i,
  input wire logic                         s_axis_tready_o,
  input wire logic [esc_pkg::InTdataW-1:0] s_axis_tdata_i,
  input wire logic                         m_axis_tvalid_o,
  input wire logic                         m_axis_tready_i,
  input wire logic [esc_pkg::OutW-1:0]     m_axis_tdata_o
);

  logic unused;
  assign unused = ^{s_axis_tvalid_i, s_axis_tdata_i};

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output stall");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output item dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output item changed while stalled");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[5:0] < 6'd60) && (m_axis_tdata_o[11:6] < 6'd60)
      && (m_axis_tdata_o[16:12] < 5'd24) && (m_axis_tdata_o[39:37] < 3'd7))
    else $error("time of day or weekday out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[21:17] != 5'd0) && (m_axis_tdata_o[25:22] != 4'd0)
      && (m_axis_tdata_o[25:22] < 4'd13) && (m_axis_tdata_o[36:26] >= 11'd1970)
      && (m_axis_tdata_o[36:26] < 11'd2039))
    else $error("date out of range");

endmodule

bind epoch_seconds_to_calendar_unit esc_checker u_esc_checker (.*);
`default_nettype wire

@@ tb/calendar_result_check.sv @@
// Checker: watches both channels, predicts each calendar date and compares field by field.
`timescale 1ns / 1ps
module calendar_result_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [esc_pkg::InTdataW-1:0]  s_axis_tdata_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic [esc_pkg::OutW-1:0]      m_axis_tdata_i,
  output int                            mismatches_o,
  output int                            pending_o,
  output int                            compared_o
);

  typedef struct packed {
    logic [esc_pkg::WdayW-1:0] weekday;
    logic [esc_pkg::YearW-1:0] year;
    logic [esc_pkg::MonW-1:0]  month;
    logic [esc_pkg::DomW-1:0]  day_of_month;
    logic [esc_pkg::HourW-1:0] hour;
    logic [esc_pkg::MinW-1:0]  minute;
    logic [esc_pkg::SecW-1:0]  second;
  } cal_date_t;

  cal_date_t expected_dates[$];
  int        mismatch_cnt = 0;
  int        compare_cnt = 0;

  function automatic int unsigned month_length(input int unsigned mon, input bit leap);
    int unsigned len;
    case (mon)
      1:       len = leap ? 29 : 28;
      3, 5, 8, 10: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  function automatic cal_date_t to_calendar(input logic [esc_pkg::InW-1:0] secs);
    int unsigned t, days, hms, rest, yr, d, mon, ylen;
    cal_date_t r;
    t = secs;
    days = t / 86400;
    hms = t % 86400;
    rest = hms % 3600;
    r.hour = 5'(hms / 3600);
    r.minute = 6'(rest / 60);
    r.second = 6'(rest % 60);
    r.weekday = 3'((days + 4) % 7);
    yr = 1970;
    d = days;
    ylen = 365;
    while (d >= ylen) begin
      d -= ylen;
      yr++;
      ylen = (yr % 4 == 0) ? 366 : 365;
    end
    mon = 0;
    while (mon < 11 && d >= month_length(mon, yr % 4 == 0)) begin
      d -= month_length(mon, yr % 4 == 0);
      mon++;
    end
    r.day_of_month = 5'(d + 1);
    r.month = 4'(mon + 1);
    r.year = 11'(yr);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s got %0d, want %0d", $time, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    cal_date_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_dates.push_back(to_calendar(s_axis_tdata_i[esc_pkg::InW-1:0]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i;
        if (expected_dates.size() == 0) begin
          report_mismatch("unexpected item, year", got.year, 0);
        end else begin
          want = expected_dates.pop_front();
          compare_cnt++;
          if (got.second != want.second) report_mismatch("second", got.second, want.second);
          if (got.minute != want.minute) report_mismatch("minute", got.minute, want.minute);
          if (got.hour != want.hour) report_mismatch("hour", got.hour, want.hour);
          if (got.day_of_month != want.day_of_month) begin
            report_mismatch("day_of_month", got.day_of_month, want.day_of_month);
          end
          if (got.month != want.month) report_mismatch("month", got.month, want.month);
          if (got.year != want.year) report_mismatch("year", got.year, want.year);
          if (got.weekday != want.weekday) begin
            report_mismatch("weekday", got.weekday, want.weekday);
          end
        end
      end
    end
    mismatches_o <= mismatch_cnt;
    pending_o <= expected_dates.size();
    compared_o <= compare_cnt;
  end

endmodule

@@ tb/epoch_seconds_to_calendar_unit_test.sv @@
// Testbench top: drives timestamps under varied idling and gives the verdict.
`timescale 1ns / 1ps
module epoch_seconds_to_calendar_unit_test;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [esc_pkg::InTdataW-1:0]  s_tdata;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [esc_pkg::OutW-1:0]      m_tdata;
  int                            mismatches;
  int                            pending;
  int                            compared;
  int                            send_idle_pct = 0;
  int                            recv_idle_pct = 0;
  int                            sent_cnt = 0;

  logic [esc_pkg::InW-1:0] corner_secs [20] = '{
    31'd0, 31'd1, 31'd59, 31'd60, 31'd3599, 31'd3600, 31'd86399, 31'd86400,
    31'd31535999, 31'd31536000, 31'd36633600, 31'd68169600, 31'd94694399,
    31'd951782400, 31'd951868800, 31'd978307199, 31'h2AAAAAAA, 31'h55555555,
    31'h40000000, 31'h7FFFFFFF
  };

  always #5 clk = ~clk;

  epoch_seconds_to_calendar_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  calendar_result_check i_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .compared_o      (compared)
  );

  always @(posedge clk) begin
    m_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
  end

  function automatic logic [esc_pkg::InW-1:0] pick_secs();
    longint v;
    case ($urandom_range(3))
      0:       v = $urandom & 32'h7FFF_FFFF;
      1:       v = longint'($urandom_range(24855)) * 86400 + ($urandom_range(1) ? 86399 : 0);
      2:       v = 64'h7FFF_FFFF - $urandom_range(200000);
      default: v = $urandom_range(100000000);
    endcase
    if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
    return v[esc_pkg::InW-1:0];
  endfunction

  task automatic send_secs(input logic [esc_pkg::InW-1:0] secs);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, secs};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_cnt++;
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 16;
    recv_idle_pct = 48;
    foreach (corner_secs[i]) send_secs(corner_secs[i]);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 48 : 0;
      recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 16 : 0;
      repeat (284) send_secs(pick_secs());
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Converted %0d timestamps (%0d at calendar corners) over three idling mixes.",
             sent_cnt, $size(corner_secs));
    $display("Compared %0d dates field by field.", compared);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/esc_pkg.sv
rtl/epoch_seconds_to_calendar_unit.sv
rtl/esc_checker.sv
tb/calendar_result_check.sv
tb/epoch_seconds_to_calendar_unit_test.sv
